// ===== hdl/dqc_pkg.sv =====
package dqc_pkg;

    // Header layout and length limits.
    localparam logic [9:0]  HDR_LEN     = 10'd12;
    localparam logic [9:0]  POS_MAX     = 10'd1023;
    localparam logic [9:0]  MAX_PAYLOAD = 10'd512;
    localparam logic [10:0] IP_UDP_HDRS = 11'd44;
    localparam logic [8:0]  QLEN_MAX    = 9'd511;
    localparam logic [10:0] RLEN_MAX    = 11'd1023;

    // Expected header and question values.
    localparam logic [15:0] STD_QUERY_FLAGS = 16'h0100;
    localparam logic [15:0] QTYPE_A         = 16'h0001;
    localparam logic [15:0] QCLASS_IN       = 16'h0001;
    localparam logic [9:0]  QDCOUNT_LO_POS  = 10'd5;

    typedef enum logic [2:0] {
        V_OK     = 3'd0,
        V_SHORT  = 3'd1,
        V_LONG   = 3'd2,
        V_FLAGS  = 3'd3,
        V_COUNTS = 3'd4,
        V_NAME   = 3'd5,
        V_TYPE   = 3'd6,
        V_CLASS  = 3'd7
    } t_verdict;

    typedef struct packed {
        t_verdict    verdict;
        logic [15:0] query_id;
        logic [8:0]  question_len;
        logic [9:0]  reply_len;
    } t_result;

endpackage

// ===== hdl/dqc_if.sv =====
// Byte stream request channel.
interface dqc_req_if;
    logic       valid;
    logic       ready;
    logic [7:0] payload_byte;
    logic       last;

    modport source (output valid, output payload_byte, output last, input ready);
    modport sink   (input valid, input payload_byte, input last, output ready);
endinterface

// Verdict channel.
interface dqc_rsp_if;
    logic       valid;
    logic       ready;
    logic [2:0] verdict;
    logic [15:0] query_id;
    logic [8:0] question_len;
    logic [9:0] reply_len;

    modport source (output valid, output verdict, output query_id, output question_len,
                    output reply_len, input ready);
    modport sink   (input valid, input verdict, input query_id, input question_len,
                    input reply_len, output ready);
endinterface

// ===== hdl/dns_query_checker.sv =====
// Channel   Dir  Payload                                        Handshake
// i_req     in   payload_byte[7:0], last                        valid/ready
// o_rsp     out  verdict[2:0], query_id[15:0],                  valid/ready
//                question_len[8:0], reply_len[9:0]
//
// One request per cycle sustained while no final byte is held back. A byte
// is held in the input register, then the tracker updates its header state
// and the verdict of a final byte lands in the result register.
// Reset (i_rst_n low, synchronous) empties both registers and clears the tracker.
// Only a final byte waits on a full, stalled result register; other bytes pass.
module dns_query_checker (
    input  logic i_clk,
    input  logic i_rst_n,
    dqc_req_if.sink   i_req,
    dqc_rsp_if.source o_rsp
);
    import dqc_pkg::*;

    // Input register.
    logic       r_in_valid;
    logic [7:0] r_in_byte;
    logic       r_in_last;

    // Result register.
    logic    r_out_valid;
    t_result r_out;

    t_result trk_result;
    logic    adv;

    // The tracker consumes a byte unless it is a final byte facing a held verdict.
    assign adv         = r_in_valid && (!r_in_last || !r_out_valid || o_rsp.ready);
    assign i_req.ready = !r_in_valid || adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_req.ready) begin
            r_in_valid <= i_req.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.ready && i_req.valid) begin
            r_in_byte <= i_req.payload_byte;
            r_in_last <= i_req.last;
        end
    end

    dqc_tracker u_tracker (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (adv),
        .i_byte   (r_in_byte),
        .i_last   (r_in_last),
        .o_result (trk_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (adv && r_in_last) begin
            r_out_valid <= 1'b1;
        end else if (o_rsp.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv && r_in_last) begin
            r_out <= trk_result;
        end
    end

    assign o_rsp.valid        = r_out_valid;
    assign o_rsp.verdict      = r_out.verdict;
    assign o_rsp.query_id     = r_out.query_id;
    assign o_rsp.question_len = r_out.question_len;
    assign o_rsp.reply_len    = r_out.reply_len;

    a_final_byte_gives_verdict: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        adv && r_in_last |=> r_out_valid)
        else $error("final byte did not load a verdict");

endmodule

// ===== hdl/dqc_tracker.sv =====
module dqc_tracker (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_step,
    input  logic [7:0]       i_byte,
    input  logic             i_last,
    output dqc_pkg::t_result o_result
);
    import dqc_pkg::*;

    logic [9:0]  r_pos, n_pos;
    logic [15:0] r_id, n_id;
    logic [15:0] r_flags, n_flags;
    logic        r_counts_bad, n_counts_bad;
    logic [9:0]  r_boundary, n_boundary;
    logic        r_name_done, n_name_done;
    logic [9:0]  r_name_end, n_name_end;
    logic [31:0] r_tail, n_tail;

    logic [10:0] nb;
    logic [9:0]  qdiff;
    logic [10:0] rsum;
    logic [10:0] name_end5;
    logic [7:0]  want;

    always_comb begin
        n_pos        = (r_pos < POS_MAX) ? r_pos + 10'd1 : POS_MAX;
        n_id         = r_id;
        n_flags      = r_flags;
        n_counts_bad = r_counts_bad;
        n_boundary   = r_boundary;
        n_name_done  = r_name_done;
        n_name_end   = r_name_end;
        n_tail       = {r_tail[23:0], i_byte};
        nb           = {1'b0, r_pos} + {3'b0, i_byte} + 11'd1;
        want         = (r_pos == QDCOUNT_LO_POS) ? 8'd1 : 8'd0;

        if (r_pos < 10'd2) begin
            n_id = {r_id[7:0], i_byte};
        end else if (r_pos < 10'd4) begin
            n_flags = {r_flags[7:0], i_byte};
        end else if (r_pos < HDR_LEN) begin
            if (i_byte != want) begin
                n_counts_bad = 1'b1;
            end
        end else if (!r_name_done && r_pos == r_boundary) begin
            if (i_byte == 8'd0) begin
                n_name_done = 1'b1;
                n_name_end  = r_pos;
            end else begin
                n_boundary = (nb > {1'b0, POS_MAX}) ? POS_MAX : nb[9:0];
            end
        end
    end

    // Verdict from the state as it stands after the final byte.
    always_comb begin
        qdiff     = n_pos - HDR_LEN;
        rsum      = {1'b0, n_pos} + IP_UDP_HDRS;
        name_end5 = {1'b0, n_name_end} + 11'd5;

        o_result.query_id     = n_id;
        o_result.question_len = '0;
        o_result.reply_len    = '0;

        if (n_pos <= HDR_LEN) begin
            o_result.verdict = V_SHORT;
        end else if (n_pos >= MAX_PAYLOAD) begin
            o_result.verdict = V_LONG;
        end else begin
            o_result.question_len = (qdiff > {1'b0, QLEN_MAX}) ? QLEN_MAX : qdiff[8:0];
            o_result.reply_len    = (rsum > RLEN_MAX) ? RLEN_MAX[9:0] : rsum[9:0];
            if (n_flags != STD_QUERY_FLAGS) begin
                o_result.verdict = V_FLAGS;
            end else if (n_counts_bad) begin
                o_result.verdict = V_COUNTS;
            end else if (!n_name_done || name_end5 != {1'b0, n_pos}) begin
                o_result.verdict = V_NAME;
            end else if (n_tail[31:16] != QTYPE_A) begin
                o_result.verdict = V_TYPE;
            end else if (n_tail[15:0] != QCLASS_IN) begin
                o_result.verdict = V_CLASS;
            end else begin
                o_result.verdict = V_OK;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_step && i_last)) begin
            r_pos        <= '0;
            r_id         <= '0;
            r_flags      <= '0;
            r_counts_bad <= 1'b0;
            r_boundary   <= HDR_LEN;
            r_name_done  <= 1'b0;
            r_name_end   <= '0;
            r_tail       <= '0;
        end else if (i_step) begin
            r_pos        <= n_pos;
            r_id         <= n_id;
            r_flags      <= n_flags;
            r_counts_bad <= n_counts_bad;
            r_boundary   <= n_boundary;
            r_name_done  <= n_name_done;
            r_name_end   <= n_name_end;
            r_tail       <= n_tail;
        end
    end

    a_clear_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_step && i_last |=> r_pos == '0 && !r_name_done && r_boundary == HDR_LEN)
        else $error("tracker state not cleared after final byte");

    a_name_end_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_name_done |-> r_name_end >= HDR_LEN && r_name_end <= r_pos)
        else $error("name end outside the question section");

    a_hold_when_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_step |=> $stable(r_pos) && $stable(r_tail) && $stable(r_boundary))
        else $error("tracker state moved without a step");

endmodule

// ===== tb/dqc_verdict_monitor.sv =====
module dqc_verdict_monitor (
    input  logic i_clk,
    input  logic i_rst_n,
    dqc_req_if   i_req,
    dqc_rsp_if   i_rsp,
    output int   o_mismatches,
    output int   o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    import dqc_pkg::*;

    // Header tracker state.
    logic [9:0]  pos;
    logic [15:0] id_w;
    logic [15:0] flags_w;
    logic        cnt_bad;
    logic [9:0]  bnd;
    logic        name_seen;
    logic [9:0]  name_end;
    logic [31:0] tail;

    t_result verdicts_due[$];
    int      errs;

    task automatic clear_tracker();
        pos       = '0;
        id_w      = '0;
        flags_w   = '0;
        cnt_bad   = 1'b0;
        bnd       = HDR_LEN;
        name_seen = 1'b0;
        name_end  = '0;
        tail      = '0;
    endtask

    always @(posedge i_clk) begin : track
        int         p;
        int         nb;
        int         len;
        logic [7:0] b;
        t_result    due;
        if (!i_rst_n) begin
            clear_tracker();
            verdicts_due.delete();
            errs = 0;
        end else begin
            if (i_req.valid === 1'b1 && i_req.ready === 1'b1) begin
                p = int'(pos);
                b = i_req.payload_byte;
                if (p < 2) begin
                    id_w = {id_w[7:0], b};
                end else if (p < 4) begin
                    flags_w = {flags_w[7:0], b};
                end else if (p < int'(HDR_LEN)) begin
                    if (b != ((p == int'(QDCOUNT_LO_POS)) ? 8'd1 : 8'd0)) begin
                        cnt_bad = 1'b1;
                    end
                end else if (!name_seen && p == int'(bnd)) begin
                    if (b == 8'd0) begin
                        name_seen = 1'b1;
                        name_end  = pos;
                    end else begin
                        // label length is unsigned; boundary saturates
                        nb  = p + int'(b) + 1;
                        bnd = (nb > int'(POS_MAX)) ? POS_MAX : 10'(nb);
                    end
                end
                tail = {tail[23:0], b};
                len  = (p < int'(POS_MAX)) ? p + 1 : int'(POS_MAX);
                pos  = 10'(len);

                if (i_req.last === 1'b1) begin
                    due.query_id     = id_w;
                    due.question_len = '0;
                    due.reply_len    = '0;
                    if (len <= int'(HDR_LEN)) begin
                        due.verdict = V_SHORT;
                    end else if (len >= int'(MAX_PAYLOAD)) begin
                        due.verdict = V_LONG;
                    end else begin
                        due.question_len = (len - int'(HDR_LEN) > int'(QLEN_MAX)) ?
                                           QLEN_MAX : 9'(len - int'(HDR_LEN));
                        due.reply_len    = (len + int'(IP_UDP_HDRS) > int'(RLEN_MAX)) ?
                                           10'(RLEN_MAX) : 10'(len + int'(IP_UDP_HDRS));
                        if (flags_w != STD_QUERY_FLAGS)
                            due.verdict = V_FLAGS;
                        else if (cnt_bad)
                            due.verdict = V_COUNTS;
                        // root byte, then type and class: four bytes after it
                        else if (!name_seen || int'(name_end) + 5 != len)
                            due.verdict = V_NAME;
                        else if (tail[31:16] != QTYPE_A)
                            due.verdict = V_TYPE;
                        else if (tail[15:0] != QCLASS_IN)
                            due.verdict = V_CLASS;
                        else
                            due.verdict = V_OK;
                    end
                    verdicts_due.push_back(due);
                    clear_tracker();
                end
            end

            if (i_rsp.valid === 1'b1 && i_rsp.ready === 1'b1) begin
                if (verdicts_due.size() == 0) begin
                    errs++;
                    if (errs <= 10)
                        $display("unexpected verdict: v=%0d id=%h ql=%0d rl=%0d",
                                 i_rsp.verdict, i_rsp.query_id, i_rsp.question_len,
                                 i_rsp.reply_len);
                end else begin
                    due = verdicts_due.pop_front();
                    if (i_rsp.verdict !== due.verdict || i_rsp.query_id !== due.query_id ||
                        i_rsp.question_len !== due.question_len ||
                        i_rsp.reply_len !== due.reply_len) begin
                        errs++;
                        if (errs <= 10)
                            $display("verdict mismatch: exp v=%0d id=%h ql=%0d rl=%0d,",
                                     due.verdict, due.query_id, due.question_len,
                                     due.reply_len,
                                     " got v=%0d id=%h ql=%0d rl=%0d",
                                     i_rsp.verdict, i_rsp.query_id,
                                     i_rsp.question_len, i_rsp.reply_len);
                    end
                end
            end
        end
        o_mismatches <= errs;
        o_pending    <= verdicts_due.size();
    end

endmodule

// ===== tb/tb.sv =====
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import dqc_pkg::*;

    // Run sizing: random part stops after this many bytes and packets.
    localparam int CYCLE_LIMIT    = 500000;
    localparam int RANDOM_BYTES   = 300;
    localparam int RANDOM_PACKETS = 8;
    localparam int QUIET_BYTES    = 230;    // no idling on either side past this

    // Corruptions applied to an otherwise well-formed query.
    typedef enum int {
        MUT_FLAGS,
        MUT_COUNTS,
        MUT_TYPE,
        MUT_CLASS,
        MUT_EXTRA,
        MUT_TRUNC,
        MUT_LABEL
    } t_mutation;

    logic i_clk = 1'b0;
    logic i_rst_n;
    bit   calm;
    int   cycles;
    int   sent_bytes;
    int   bad_count;
    int   due_count;

    // Payload being assembled for the next burst of requests.
    logic [7:0] pkt[$];

    dqc_req_if req_ch ();
    dqc_rsp_if rsp_ch ();

    dns_query_checker u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch),
        .o_rsp   (rsp_ch)
    );

    dqc_verdict_monitor u_monitor (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_req        (req_ch),
        .i_rsp        (rsp_ch),
        .o_mismatches (bad_count),
        .o_pending    (due_count)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // Watchdog: a hang or a lost verdict ends here.
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // Verdict side back-pressure: random stall and open bursts, always open
    // once the run goes quiet.
    initial begin : rsp_pacing
        int   n;
        logic lvl;
        rsp_ch.ready = 1'b0;
        forever begin
            if (!calm && $urandom_range(0, 2) == 0) begin
                n   = $urandom_range(1, 18);
                lvl = 1'b0;
            end else begin
                n   = $urandom_range(1, 30);
                lvl = 1'b1;
            end
            repeat (n) begin
                @(negedge i_clk);
                rsp_ch.ready <= calm ? 1'b1 : lvl;
            end
        end
    end

    // Well-formed standard query: random id, flags 0x0100, counts 1/0/0/0, a
    // name of name_len bytes (labels plus root byte), type A, class IN.
    task automatic build_query(input int name_len, input int lbl_lo, input int lbl_hi);
        int rem;
        int l;
        int hi;
        int i;
        pkt.delete();
        pkt.push_back(8'($urandom_range(0, 255)));
        pkt.push_back(8'($urandom_range(0, 255)));
        pkt.push_back(STD_QUERY_FLAGS[15:8]);
        pkt.push_back(STD_QUERY_FLAGS[7:0]);
        for (i = 4; i < int'(HDR_LEN); i++)
            pkt.push_back((i == int'(QDCOUNT_LO_POS)) ? 8'd1 : 8'd0);
        // a two-byte name cannot be built, stretch it to three
        rem = (name_len == 2) ? 3 : name_len;
        while (rem > 1) begin
            hi = (lbl_hi < rem - 2) ? lbl_hi : rem - 2;
            l  = $urandom_range((lbl_lo < hi) ? lbl_lo : hi, hi);
            // never leave exactly two bytes: one label byte plus root won't fit
            if (rem - l - 1 == 2)
                l = (l < 255) ? l + 1 : l - 1;
            pkt.push_back(8'(l));
            repeat (l) pkt.push_back(8'($urandom_range(0, 255)));
            rem -= l + 1;
        end
        pkt.push_back(8'd0);
        pkt.push_back(QTYPE_A[15:8]);
        pkt.push_back(QTYPE_A[7:0]);
        pkt.push_back(QCLASS_IN[15:8]);
        pkt.push_back(QCLASS_IN[7:0]);
    endtask

    // One request; valid stays high across back-to-back requests.
    task automatic send_byte(input logic [7:0] b, input logic lst, input bit gappy);
        int n;
        if (gappy && !calm && $urandom_range(0, 9) == 0) begin
            n = $urandom_range(1, 18);
            @(negedge i_clk);
            req_ch.valid <= 1'b0;
            repeat (n - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        req_ch.valid        <= 1'b1;
        req_ch.payload_byte <= b;
        req_ch.last         <= lst;
        do @(posedge i_clk); while (req_ch.ready !== 1'b1);
        sent_bytes++;
    endtask

    task automatic send_packet(input bit gappy);
        int i;
        for (i = 0; i < pkt.size(); i++)
            send_byte(pkt[i], i == pkt.size() - 1, gappy);
    endtask

    initial begin : stimulus
        int        start;
        int        n;
        int        j;
        int        kind;
        t_mutation mut;

        i_rst_n             = 1'b0;
        req_ch.valid        = 1'b0;
        req_ch.payload_byte = '0;
        req_ch.last         = 1'b0;
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // ---- directed part ----
        // smallest good query: root name only, all-ones id
        build_query(1, 1, 1);
        pkt[0] = 8'hFF;
        pkt[1] = 8'hFF;
        send_packet(1'b1);
        // one long label, length byte above 127 must read unsigned
        build_query(130, 128, 128);
        send_packet(1'b1);
        // single byte payload: id holds only what arrived
        pkt.delete();
        pkt.push_back(8'hA5);
        send_packet(1'b1);
        // header only, zero id: still short
        build_query(1, 1, 1);
        pkt[0] = 8'h00;
        pkt[1] = 8'h00;
        while (pkt.size() > 12) void'(pkt.pop_back());
        send_packet(1'b1);
        // one byte past the header: lengths reported, name check fails
        build_query(1, 1, 1);
        while (pkt.size() > 13) void'(pkt.pop_back());
        send_packet(1'b1);
        // first rejected length
        build_query(496, 1, 63);
        send_packet(1'b0);
        // flags other than a plain recursive query
        build_query(4, 1, 2);
        pkt[2] = 8'h00;
        send_packet(1'b1);
        build_query(4, 1, 2);
        pkt[2] = 8'h81;
        send_packet(1'b1);
        build_query(4, 1, 2);
        pkt[3] = 8'h01;
        send_packet(1'b1);
        // counts: no question, 128 additional records, a question count of 257
        build_query(4, 1, 2);
        pkt[5] = 8'h00;
        send_packet(1'b1);
        build_query(4, 1, 2);
        pkt[11] = 8'h80;
        send_packet(1'b1);
        build_query(4, 1, 2);
        pkt[4] = 8'h01;
        send_packet(1'b1);
        // flags and counts both wrong: flags wins
        build_query(4, 1, 2);
        pkt[3] = 8'h80;
        pkt[6] = 8'h01;
        send_packet(1'b1);
        // label pointing past the end of the payload
        build_query(10, 1, 8);
        pkt[12] = 8'hFA;
        send_packet(1'b1);
        // stray byte between root and type
        build_query(10, 1, 8);
        pkt.insert(pkt.size() - 4, 8'h00);
        send_packet(1'b1);
        // type AAAA, type 0x0101, class ANY, class with the top bit set
        build_query(12, 1, 8);
        pkt[pkt.size() - 3] = 8'h1C;
        send_packet(1'b1);
        build_query(12, 1, 8);
        pkt[pkt.size() - 4] = 8'h01;
        send_packet(1'b1);
        build_query(12, 1, 8);
        pkt[pkt.size() - 1] = 8'hFF;
        send_packet(1'b1);
        build_query(12, 1, 8);
        pkt[pkt.size() - 2] = 8'h80;
        send_packet(1'b1);

        // ---- random part ----
        // Mostly well-formed queries with random content, some corrupted in one
        // spot, plus raw noise, scrambled questions and short fragments.
        start = sent_bytes;
        n     = 0;
        while (sent_bytes - start < RANDOM_BYTES || n < RANDOM_PACKETS) begin
            calm = (sent_bytes - start >= QUIET_BYTES);
            kind = $urandom_range(0, 99);
            if (kind < 85) begin
                build_query($urandom_range(1, 40), 1, $urandom_range(1, 63));
                if (kind >= 60) begin
                    mut = t_mutation'($urandom_range(0, MUT_LABEL));
                    case (mut)
                        MUT_FLAGS: begin
                            j = $urandom_range(2, 3);
                            pkt[j] = pkt[j] ^ 8'($urandom_range(1, 255));
                        end
                        MUT_COUNTS: begin
                            j = $urandom_range(4, 11);
                            pkt[j] = pkt[j] ^ 8'($urandom_range(1, 255));
                        end
                        MUT_TYPE: begin
                            j = pkt.size() - 4 + $urandom_range(0, 1);
                            pkt[j] = pkt[j] ^ 8'($urandom_range(1, 255));
                        end
                        MUT_CLASS: begin
                            j = pkt.size() - 2 + $urandom_range(0, 1);
                            pkt[j] = pkt[j] ^ 8'($urandom_range(1, 255));
                        end
                        MUT_EXTRA: begin
                            j = $urandom_range(12, pkt.size() - 4);
                            pkt.insert(j, 8'($urandom_range(0, 255)));
                        end
                        MUT_TRUNC: begin
                            void'(pkt.pop_back());
                        end
                        default: begin
                            pkt[12] = pkt[12] ^ 8'($urandom_range(1, 255));
                        end
                    endcase
                end
            end else if (kind < 95) begin
                if (kind < 90) begin
                    // pure noise
                    pkt.delete();
                    repeat ($urandom_range(1, 60)) pkt.push_back(8'($urandom_range(0, 255)));
                end else begin
                    // good header, scrambled question
                    build_query($urandom_range(1, 40), 1, 63);
                    for (j = 12; j < pkt.size(); j++)
                        if ($urandom_range(0, 3) == 0)
                            pkt[j] = 8'($urandom_range(0, 255));
                end
            end else begin
                // fragment no longer than the header
                build_query(1, 1, 1);
                j = $urandom_range(1, 12);
                while (pkt.size() > j) void'(pkt.pop_back());
            end
            send_packet($urandom_range(0, 3) != 0);
            n++;
        end

        @(negedge i_clk);
        req_ch.valid <= 1'b0;

        // The monitor reports its pending count through a register.
        @(posedge i_clk);
        while (due_count != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);

        if (bad_count == 0 && due_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
